// File: rtl/core/bsr_pkg.sv
// Shared types and constants for the byte stream reassembler.
// Holds the ring sizing, operation codes, controller states and the
// command and status structs between controller and datapath; depends on nothing.
package bsr_pkg;

    localparam int SLOT_W   = 6;
    localparam int CAPACITY = 1 << SLOT_W;
    localparam int IDX_W    = 32;
    localparam int LEN_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int PEND_W   = 7;

    typedef enum logic [1:0] {
        OP_PUSH     = 2'd0,
        OP_END_MARK = 2'd1,
        OP_READER   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FLUSH,
        ST_EMIT,
        ST_STATUS
    } ctrl_state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic advance;
        logic load_byte;
        logic load_status;
    } dp_cmd_t;

    typedef struct packed {
        logic flush_go;
        logic head_valid;
        logic run_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/core/bsr_ctrl.sv
// Controller state machine of the byte stream reassembler.
// Sequences accept, execute, flush and result loading; depends on bsr_pkg.
module bsr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bsr_pkg::dp_status_t status,
    output bsr_pkg::dp_cmd_t    cmd
);

    bsr_pkg::ctrl_state_t state_reg;
    bsr_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bsr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bsr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bsr_pkg::ST_EXEC;
                end
            end
            bsr_pkg::ST_EXEC:
            begin
                state_next = status.flush_go ? bsr_pkg::ST_FLUSH : bsr_pkg::ST_STATUS;
            end
            bsr_pkg::ST_FLUSH:
            begin
                state_next = status.head_valid ? bsr_pkg::ST_EMIT : bsr_pkg::ST_STATUS;
            end
            bsr_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.run_last ? bsr_pkg::ST_IDLE : bsr_pkg::ST_FLUSH;
                end
            end
            bsr_pkg::ST_STATUS:
            begin
                if (status.out_free)
                begin
                    state_next = bsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        cmd             = '0;
        unique case (state_reg)
            bsr_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            bsr_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            bsr_pkg::ST_FLUSH:
            begin
                cmd.advance = status.head_valid;
            end
            bsr_pkg::ST_EMIT:
            begin
                cmd.load_byte = status.out_free;
            end
            bsr_pkg::ST_STATUS:
            begin
                cmd.load_status = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/core/bsr_datapath.sv
// Datapath of the byte stream reassembler: item register, byte ring,
// slot valid bits, stream counters and the result register; depends on bsr_pkg.
module bsr_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bsr_pkg::dp_cmd_t            cmd,
    output bsr_pkg::dp_status_t         status,
    input  logic [1:0]                  operation,
    input  logic [bsr_pkg::IDX_W-1:0]   stream_index,
    input  logic [bsr_pkg::BYTE_W-1:0]  data_byte,
    input  logic [bsr_pkg::LEN_W-1:0]   segment_length,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic                        out_valid,
    output logic [bsr_pkg::BYTE_W-1:0]  out_byte,
    output logic                        last,
    output logic [bsr_pkg::IDX_W-1:0]   next_expected,
    output logic [bsr_pkg::PEND_W-1:0]  pending_count,
    output logic                        stream_ended
);

    localparam int IW = bsr_pkg::IDX_W;
    localparam int SW = bsr_pkg::SLOT_W;
    localparam int CW = bsr_pkg::CNT_W;

    logic [1:0]                  op_reg;
    logic [IW-1:0]               idx_reg;
    logic [bsr_pkg::BYTE_W-1:0]  data_reg;
    logic [bsr_pkg::LEN_W-1:0]   len_reg;

    logic [bsr_pkg::BYTE_W-1:0]  ring [bsr_pkg::CAPACITY];
    logic [bsr_pkg::BYTE_W-1:0]  rdata_reg;

    logic [bsr_pkg::CAPACITY-1:0] valid_reg, valid_next;
    logic [IW-1:0]               next_idx_reg, next_idx_next;
    logic [IW-1:0]               reader_reg, reader_next;
    logic [IW-1:0]               end_reg, end_next;
    logic                        end_known_reg, end_known_next;
    logic                        ended_reg, ended_next;
    logic [CW-1:0]               stored_reg, stored_next;
    logic                        run_last_reg, run_last_next;

    logic                        res_valid_reg, res_valid_next;
    logic                        out_valid_reg;
    logic [bsr_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                        last_reg;
    logic [IW-1:0]               ack_reg;
    logic [bsr_pkg::PEND_W-1:0]  pend_reg;
    logic                        ended_out_reg;

    logic [IW:0]                 win_top;
    logic [IW:0]                 read_top;
    logic [IW:0]                 end_sum;
    logic [IW-1:0]               end_sat;
    logic [IW-1:0]               next_inc;
    logic [SW-1:0]               slot_w;
    logic [SW-1:0]               head;
    logic [SW-1:0]               head_nxt;
    logic                        in_win;
    logic                        do_store;
    logic                        out_free;

    assign win_top  = {1'b0, next_idx_reg} + (IW+1)'(bsr_pkg::CAPACITY);
    assign read_top = {1'b0, reader_reg} + (IW+1)'(bsr_pkg::CAPACITY);
    assign in_win   = {1'b0, idx_reg} < win_top;
    assign do_store = (op_reg == bsr_pkg::OP_PUSH) && in_win && (idx_reg >= next_idx_reg)
                      && ({1'b0, idx_reg} < read_top);
    assign end_sum  = {1'b0, idx_reg} + (IW+1)'(len_reg);
    assign end_sat  = end_sum[IW] ? '1 : end_sum[IW-1:0];
    assign next_inc = next_idx_reg + IW'(1);
    assign slot_w   = idx_reg[SW-1:0];
    assign head     = next_idx_reg[SW-1:0];
    assign head_nxt = head + SW'(1);
    assign out_free = !res_valid_reg || res_ready;

    assign status.flush_go   = in_win && ((op_reg == bsr_pkg::OP_PUSH)
                                          || (op_reg == bsr_pkg::OP_END_MARK));
    assign status.head_valid = valid_reg[head];
    assign status.run_last   = run_last_reg;
    assign status.out_free   = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= operation;
            idx_reg  <= stream_index;
            data_reg <= data_byte;
            len_reg  <= segment_length;
        end
        if (cmd.exec && do_store)
        begin
            ring[slot_w] <= data_reg;
        end
        if (cmd.advance)
        begin
            rdata_reg <= ring[head];
        end
    end

    always_comb
    begin
        valid_next     = valid_reg;
        next_idx_next  = next_idx_reg;
        reader_next    = reader_reg;
        end_next       = end_reg;
        end_known_next = end_known_reg;
        ended_next     = ended_reg;
        stored_next    = stored_reg;
        run_last_next  = run_last_reg;
        if (cmd.exec)
        begin
            case (op_reg)
                bsr_pkg::OP_PUSH:
                begin
                    if (do_store)
                    begin
                        valid_next[slot_w] = 1'b1;
                        if (!valid_reg[slot_w])
                        begin
                            stored_next = stored_reg + CW'(1);
                        end
                    end
                    if (in_win && end_known_reg && (next_idx_reg >= end_reg))
                    begin
                        ended_next = 1'b1;
                    end
                end
                bsr_pkg::OP_END_MARK:
                begin
                    if (in_win)
                    begin
                        end_next       = end_sat;
                        end_known_next = 1'b1;
                        if (next_idx_reg >= end_sat)
                        begin
                            ended_next = 1'b1;
                        end
                    end
                end
                bsr_pkg::OP_READER:
                begin
                    reader_next = (idx_reg > next_idx_reg) ? next_idx_reg : idx_reg;
                end
                default:
                begin
                    reader_next = reader_reg;
                end
            endcase
        end
        if (cmd.advance)
        begin
            valid_next[head] = 1'b0;
            if (stored_reg != '0)
            begin
                stored_next = stored_reg - CW'(1);
            end
            next_idx_next = next_inc;
            if (end_known_reg && (next_inc >= end_reg))
            begin
                ended_next = 1'b1;
            end
            run_last_next = !valid_reg[head_nxt];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            next_idx_reg  <= '0;
            reader_reg    <= '0;
            end_reg       <= '0;
            end_known_reg <= 1'b0;
            ended_reg     <= 1'b0;
            stored_reg    <= '0;
            run_last_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            next_idx_reg  <= next_idx_next;
            reader_reg    <= reader_next;
            end_reg       <= end_next;
            end_known_reg <= end_known_next;
            ended_reg     <= ended_next;
            stored_reg    <= stored_next;
            run_last_reg  <= run_last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.load_byte || cmd.load_status)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte || cmd.load_status)
        begin
            out_valid_reg <= cmd.load_byte;
            out_byte_reg  <= cmd.load_byte ? rdata_reg : '0;
            last_reg      <= cmd.load_byte ? run_last_reg : 1'b1;
            ack_reg       <= next_idx_reg;
            pend_reg      <= bsr_pkg::PEND_W'(stored_reg);
            ended_out_reg <= ended_reg;
        end
    end

    assign res_valid     = res_valid_reg;
    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign last          = last_reg;
    assign next_expected = ack_reg;
    assign pending_count = pend_reg;
    assign stream_ended  = ended_out_reg;

endmodule

// File: rtl/core/byte_stream_reassembler_unit.sv
// Top level of the byte stream reassembler.
// Joins the controller bsr_ctrl and the datapath bsr_datapath; uses bsr_pkg.
//
// Input channel (in_valid, in_ready) carries one operation per transaction:
// push a byte at its absolute stream index, mark the end of the stream, or
// move the reader position. Result channel (res_valid, res_ready) carries
// the assembled bytes in stream order, one per transaction, with the final
// result of each input item flagged by last; an item that assembles nothing
// gives a single status result with out_valid low.
// An input item is accepted and then executed; each assembled byte then takes
// one ring read and one load of the result register. A status result is
// loaded in the status step after execute, or after a flush check that finds
// no byte, following a push or end mark in the window that assembles nothing.
// Each byte needs its own ring read: the byte ring has a single read port,
// whose read data is registered before it reaches the result register.
// One item is worked on at a time; in_ready is high while the block is idle,
// even while its last result still waits in the result register.
// When the receiver stalls, the block holds in its current step until the
// result register frees up.
// Reset clears the slot valid bits, the stream counters and the result valid
// flag at once; no clearing pass is needed.
module byte_stream_reassembler_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [bsr_pkg::IDX_W-1:0]   stream_index,
    input  logic [bsr_pkg::BYTE_W-1:0]  data_byte,
    input  logic [bsr_pkg::LEN_W-1:0]   segment_length,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic                        out_valid,
    output logic [bsr_pkg::BYTE_W-1:0]  out_byte,
    output logic                        last,
    output logic [bsr_pkg::IDX_W-1:0]   next_expected,
    output logic [bsr_pkg::PEND_W-1:0]  pending_count,
    output logic                        stream_ended
);

    bsr_pkg::dp_cmd_t    cmd;
    bsr_pkg::dp_status_t status;

    bsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bsr_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .operation      (operation),
        .stream_index   (stream_index),
        .data_byte      (data_byte),
        .segment_length (segment_length),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .out_valid      (out_valid),
        .out_byte       (out_byte),
        .last           (last),
        .next_expected  (next_expected),
        .pending_count  (pending_count),
        .stream_ended   (stream_ended)
    );

    a_one_item_at_a_time: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready
    ) else $error("A second item was accepted while one was being executed.");

    a_no_accept_mid_run: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && !last |-> !in_ready
    ) else $error("Input was offered ready while an item still had results to give.");

    a_result_only_when_loaded: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!in_ready)
    ) else $error("A result appeared without an item having been executed.");

endmodule
